// ===== design/tcphb_pkg.sv =====
// Shared types, constants and checksum helpers for the IPv4/TCP header builder.
// No dependencies; imported by every module in this block.
package tcphb_pkg;

  localparam int unsigned HdrWords   = 20;
  localparam logic [16:0] MaxPayload = 17'd65495;
  localparam logic [16:0] BytesSat   = 17'h1ffff;
  localparam logic [15:0] IpVerIhl   = 16'h4500;
  localparam logic [15:0] IpTtlProto = 16'hff06;
  localparam logic [15:0] ProtoTcp   = 16'd6;
  localparam logic [15:0] TcpWindow  = 16'd1024;
  localparam logic [15:0] IpHdrLen   = 16'd20;
  localparam logic [16:0] IpTcpHdr   = 17'd40;
  localparam logic [4:0]  LastIdx    = 5'(HdrWords - 1);

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_SRC_ADDR  = 3'd0,
    CFG_DST_ADDR  = 3'd1,
    CFG_SRC_PORT  = 3'd2,
    CFG_DST_PORT  = 3'd3,
    CFG_IP_IDENT  = 3'd4
  } cfg_reg_t;

  // header word positions
  typedef enum logic [4:0] {
    W_VER_IHL = 5'd0,  W_TOT_LEN = 5'd1,  W_IDENT   = 5'd2,  W_FRAG    = 5'd3,
    W_TTL     = 5'd4,  W_IP_CSUM = 5'd5,  W_SA_HI   = 5'd6,  W_SA_LO   = 5'd7,
    W_DA_HI   = 5'd8,  W_DA_LO   = 5'd9,  W_SPORT   = 5'd10, W_DPORT   = 5'd11,
    W_SEQ_HI  = 5'd12, W_SEQ_LO  = 5'd13, W_ACK_HI  = 5'd14, W_ACK_LO  = 5'd15,
    W_OFF_FLG = 5'd16, W_WINDOW  = 5'd17, W_TCP_CSUM = 5'd18, W_URG    = 5'd19
  } hdr_word_t;

  typedef struct packed {
    logic [15:0] payload_word;
    logic [1:0]  byte_count;
    logic        last_item;
    logic [31:0] sequence_number;
    logic [31:0] ack_number;
    logic [2:0]  tcp_flags;
  } in_item_t;

  typedef struct packed {
    logic [15:0] header_word;
    logic [4:0]  word_index;
    logic        end_of_header;
    logic        length_error;
  } out_item_t;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [15:0] ip_ident;
  } cfg_regs_t;

  // one finished packet handed from the accumulator to the emitter
  typedef struct packed {
    logic [15:0] payload_sum;
    logic [16:0] payload_bytes;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [2:0]  flags;
  } pkt_desc_t;

  function automatic logic [19:0] ext16(input logic [15:0] x);
    return {4'd0, x};
  endfunction

  // end-around-carry fold of a wide raw sum down to 16 bits
  function automatic logic [15:0] fold20(input logic [19:0] x);
    logic [16:0] f1;
    logic [16:0] f2;
    f1 = {1'b0, x[15:0]} + {13'd0, x[19:16]};
    f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
    return f2[15:0];
  endfunction

  // data offset 5 with FIN, PSH, ACK in their bit positions
  function automatic logic [15:0] off_flags(input logic [2:0] f);
    return {4'h5, 7'd0, f[2], f[1], 2'b00, f[0]};
  endfunction

endpackage

// ===== design/tcphb_accum.sv =====
// Payload accumulator: running one's-complement sum and byte count.
// Hands a packet descriptor to the emitter on the last item. Uses tcphb_pkg.
module tcphb_accum import tcphb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      desc_valid,
  output pkt_desc_t desc,
  input  logic      desc_take
);

  logic [15:0] sum_r, sum_nxt;
  logic [16:0] bytes_r, bytes_nxt;
  logic        desc_valid_r, desc_valid_nxt;
  pkt_desc_t   desc_r, desc_nxt;

  logic [15:0] word_m;
  logic [1:0]  cnt_c;
  logic [16:0] add_s;
  logic [17:0] add_b;
  logic        acc_ok;

  // a last item waits only while a descriptor is still pending
  assign in_ready = !in_item.last_item || !desc_valid_r || desc_take;
  assign acc_ok   = in_valid && in_ready;

  // mask the word to its valid bytes; a count of three counts as two
  always_comb begin
    cnt_c  = (in_item.byte_count == 2'd3) ? 2'd2 : in_item.byte_count;
    case (cnt_c)
      2'd0:    word_m = 16'd0;
      2'd1:    word_m = {in_item.payload_word[15:8], 8'd0};
      default: word_m = in_item.payload_word;
    endcase
    add_s = {1'b0, sum_r} + {1'b0, word_m};
    add_b = {1'b0, bytes_r} + {16'd0, cnt_c};
  end

  // next state of sum, count and descriptor
  always_comb begin
    sum_nxt        = sum_r;
    bytes_nxt      = bytes_r;
    desc_nxt       = desc_r;
    desc_valid_nxt = desc_valid_r && !desc_take;
    if (acc_ok) begin
      sum_nxt   = 16'(add_s[15:0] + {15'd0, add_s[16]});
      bytes_nxt = add_b[17] ? BytesSat : add_b[16:0];
      if (in_item.last_item) begin
        desc_nxt.payload_sum   = sum_nxt;
        desc_nxt.payload_bytes = bytes_nxt;
        desc_nxt.seq           = in_item.sequence_number;
        desc_nxt.ack           = in_item.ack_number;
        desc_nxt.flags         = in_item.tcp_flags;
        desc_valid_nxt         = 1'b1;
        sum_nxt                = 16'd0;
        bytes_nxt              = 17'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r        <= 16'd0;
      bytes_r      <= 17'd0;
      desc_valid_r <= 1'b0;
    end else begin
      sum_r        <= sum_nxt;
      bytes_r      <= bytes_nxt;
      desc_valid_r <= desc_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
  end

  assign desc_valid = desc_valid_r;
  assign desc       = desc_r;

  // a take only happens on a pending descriptor
  a_take_pending: assert property (@(posedge clk) disable iff (!rst_n)
    desc_take |-> desc_valid_r)
    else $error("descriptor taken while none pending");

  // a refused item is always a last item behind a pending descriptor
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |-> (in_item.last_item && desc_valid_r))
    else $error("input stalled without a pending descriptor");

  // state is cleared right after a last item is taken
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_ok && in_item.last_item) |=> (sum_r == 16'd0 && bytes_r == 17'd0))
    else $error("accumulator not cleared after last item");

endmodule

// ===== design/tcphb_emit.sv =====
// Header emitter: checksum raw sums on load, then 20 header words in order.
// Uses tcphb_pkg; configuration values come from the top level.
module tcphb_emit import tcphb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t cfg,
  input  logic      desc_valid,
  input  pkt_desc_t desc,
  output logic      desc_take,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  // packet registers loaded from the descriptor
  logic [15:0] tot_len_r;
  logic        err_r;
  logic [31:0] seq_r, ack_r;
  logic [2:0]  flags_r;
  logic [19:0] ip_raw_r, tcp_raw_r;

  logic        emit, wrap, load;
  logic        err_c;
  logic [15:0] tot_len_c, tcp_len_c;
  logic [19:0] ip_raw_c, tcp_raw_c;
  logic [15:0] word_c;

  assign emit      = busy_r && (!out_valid_r || out_ready);
  assign wrap      = emit && (cnt_r == LastIdx);
  assign load      = desc_valid && (!busy_r || wrap);
  assign desc_take = load;

  // lengths and raw checksum sums for the incoming descriptor
  always_comb begin
    err_c     = desc.payload_bytes > MaxPayload;
    tot_len_c = err_c ? 16'hffff : 16'(desc.payload_bytes + IpTcpHdr);
    tcp_len_c = tot_len_c - IpHdrLen;
    ip_raw_c  = ext16(IpVerIhl) + ext16(tot_len_c) + ext16(cfg.ip_ident)
              + ext16(IpTtlProto)
              + ext16(cfg.source_address[31:16]) + ext16(cfg.source_address[15:0])
              + ext16(cfg.destination_address[31:16])
              + ext16(cfg.destination_address[15:0]);
    tcp_raw_c = ext16(desc.payload_sum)
              + ext16(cfg.source_address[31:16]) + ext16(cfg.source_address[15:0])
              + ext16(cfg.destination_address[31:16])
              + ext16(cfg.destination_address[15:0])
              + ext16(ProtoTcp) + ext16(tcp_len_c)
              + ext16(cfg.source_port) + ext16(cfg.destination_port)
              + ext16(desc.seq[31:16]) + ext16(desc.seq[15:0])
              + ext16(desc.ack[31:16]) + ext16(desc.ack[15:0])
              + ext16(off_flags(desc.flags)) + ext16(TcpWindow);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tot_len_r <= tot_len_c;
      err_r     <= err_c;
      seq_r     <= desc.seq;
      ack_r     <= desc.ack;
      flags_r   <= desc.flags;
      ip_raw_r  <= ip_raw_c;
      tcp_raw_r <= tcp_raw_c;
    end
  end

  // header word select
  always_comb begin
    case (hdr_word_t'(cnt_r))
      W_VER_IHL:  word_c = IpVerIhl;
      W_TOT_LEN:  word_c = tot_len_r;
      W_IDENT:    word_c = cfg.ip_ident;
      W_TTL:      word_c = IpTtlProto;
      W_IP_CSUM:  word_c = ~fold20(ip_raw_r);
      W_SA_HI:    word_c = cfg.source_address[31:16];
      W_SA_LO:    word_c = cfg.source_address[15:0];
      W_DA_HI:    word_c = cfg.destination_address[31:16];
      W_DA_LO:    word_c = cfg.destination_address[15:0];
      W_SPORT:    word_c = cfg.source_port;
      W_DPORT:    word_c = cfg.destination_port;
      W_SEQ_HI:   word_c = seq_r[31:16];
      W_SEQ_LO:   word_c = seq_r[15:0];
      W_ACK_HI:   word_c = ack_r[31:16];
      W_ACK_LO:   word_c = ack_r[15:0];
      W_OFF_FLG:  word_c = off_flags(flags_r);
      W_WINDOW:   word_c = TcpWindow;
      W_TCP_CSUM: word_c = ~fold20(tcp_raw_r);
      default:    word_c = 16'd0;
    endcase
  end

  // sequencer and output register
  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt         = 1'b1;
      out_nxt.header_word   = word_c;
      out_nxt.word_index    = cnt_r;
      out_nxt.end_of_header = (cnt_r == LastIdx);
      out_nxt.length_error  = err_r;
      cnt_nxt               = wrap ? 5'd0 : 5'(cnt_r + 5'd1);
      if (wrap) busy_nxt = 1'b0;
    end
    if (load) busy_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // word counter stays in the header and rests at zero when idle
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= LastIdx) && (busy_r || cnt_r == 5'd0))
    else $error("word counter out of range");

  // a new packet loads only when the previous header is done
  a_load_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (load && busy_r) |-> (cnt_r == LastIdx))
    else $error("packet loaded mid-header");

  // the last word with nothing queued leaves the emitter idle
  a_idle_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (wrap && !desc_valid) |=> !busy_r)
    else $error("emitter still busy after last header word");

endmodule

// ===== design/tcp_ipv4_header_builder.sv =====
// IPv4/TCP header builder top level: configuration registers, accumulator, emitter.
// Depends on tcphb_pkg, tcphb_accum and tcphb_emit.
// Throughput: one payload item per cycle unless a last item stalls; each header is 20 words on the output.
// A last item is registered as a descriptor, loaded into the emitter, then its first header word is registered out.
// A last item stalls only while one header is emitting and another is queued.
// Reset (synchronous, rst_n low) clears config, sums, counts and valids; no clearing pass.
module tcp_ipv4_header_builder import tcphb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_regs_t cfg_r, cfg_nxt;
  logic      desc_valid, desc_take;
  pkt_desc_t desc;

  // register write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SRC_ADDR: cfg_nxt.source_address      = cfg_wdata;
        CFG_DST_ADDR: cfg_nxt.destination_address = cfg_wdata;
        CFG_SRC_PORT: cfg_nxt.source_port         = cfg_wdata[15:0];
        CFG_DST_PORT: cfg_nxt.destination_port    = cfg_wdata[15:0];
        CFG_IP_IDENT: cfg_nxt.ip_ident            = cfg_wdata[15:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tcphb_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_take  (desc_take)
  );

  tcphb_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_take  (desc_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

// ===== bench/tcphb_checker.sv =====
// Checker for the IPv4/TCP header builder: watches config, payload and header channels,
// predicts every header word and compares it with what the block emits.
// Depends on tcphb_pkg for the item types, register indexes and header constants.
module tcphb_checker import tcphb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_item,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          mismatches,
  output int          pending,
  output int          items_taken,
  output int          words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_regs_t   regs;
  logic [15:0] pay_sum;
  logic [16:0] pay_bytes;
  out_item_t   hdr_q[$];
  int          n_err;
  int          n_items;
  int          n_words;

  // 16-bit one's-complement add with end-around carry
  function automatic logic [15:0] oc_sum(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // fold one payload item into the running sum; a last item queues the whole header
  task automatic absorb_item(input in_item_t it);
    logic [1:0]  cnt;
    logic [15:0] w;
    logic [17:0] nb;
    logic        err;
    logic [15:0] tot_len;
    logic [15:0] tcp_len;
    logic [15:0] sum;
    logic [15:0] hdr [HdrWords];
    out_item_t   o;
    cnt = (it.byte_count > 2'd2) ? 2'd2 : it.byte_count;
    case (cnt)
      2'd2: w = it.payload_word;
      2'd1: w = {it.payload_word[15:8], 8'h00};
      default: w = '0;
    endcase
    pay_sum = oc_sum(pay_sum, w);
    nb = {1'b0, pay_bytes} + 18'(cnt);
    pay_bytes = (nb > {1'b0, BytesSat}) ? BytesSat : nb[16:0];
    if (it.last_item) begin
      err = (pay_bytes > MaxPayload);
      tot_len = err ? 16'hffff : 16'(pay_bytes + IpTcpHdr);
      tcp_len = tot_len - IpHdrLen;
      hdr[W_VER_IHL]  = IpVerIhl;
      hdr[W_TOT_LEN]  = tot_len;
      hdr[W_IDENT]    = regs.ip_ident;
      hdr[W_FRAG]     = '0;
      hdr[W_TTL]      = IpTtlProto;
      hdr[W_IP_CSUM]  = '0;
      hdr[W_SA_HI]    = regs.source_address[31:16];
      hdr[W_SA_LO]    = regs.source_address[15:0];
      hdr[W_DA_HI]    = regs.destination_address[31:16];
      hdr[W_DA_LO]    = regs.destination_address[15:0];
      hdr[W_SPORT]    = regs.source_port;
      hdr[W_DPORT]    = regs.destination_port;
      hdr[W_SEQ_HI]   = it.sequence_number[31:16];
      hdr[W_SEQ_LO]   = it.sequence_number[15:0];
      hdr[W_ACK_HI]   = it.ack_number[31:16];
      hdr[W_ACK_LO]   = it.ack_number[15:0];
      // FIN stays at bit 0, PSH moves to bit 3, ACK to bit 4
      hdr[W_OFF_FLG]  = 16'h5000 | 16'(it.tcp_flags[0]) | (16'(it.tcp_flags[1]) << 3)
                        | (16'(it.tcp_flags[2]) << 4);
      hdr[W_WINDOW]   = TcpWindow;
      hdr[W_TCP_CSUM] = '0;
      hdr[W_URG]      = '0;
      // IP header checksum over the ten IP words
      sum = '0;
      for (int k = 0; k <= W_DA_LO; k++) sum = oc_sum(sum, hdr[k]);
      hdr[W_IP_CSUM] = ~sum;
      // TCP checksum: payload, pseudo-header, then the TCP header
      sum = pay_sum;
      for (int k = W_SA_HI; k <= W_DA_LO; k++) sum = oc_sum(sum, hdr[k]);
      sum = oc_sum(sum, ProtoTcp);
      sum = oc_sum(sum, tcp_len);
      for (int k = W_SPORT; k < HdrWords; k++) sum = oc_sum(sum, hdr[k]);
      hdr[W_TCP_CSUM] = ~sum;
      for (int k = 0; k < HdrWords; k++) begin
        o.header_word   = hdr[k];
        o.word_index    = 5'(k);
        o.end_of_header = (5'(k) == LastIdx);
        o.length_error  = err;
        hdr_q.push_back(o);
      end
      pay_sum = '0;
      pay_bytes = '0;
    end
  endtask

  task automatic report(input string what, input out_item_t want, input out_item_t got);
    n_err++;
    if (n_err <= 10) begin
      $display("%s at %0t: expected idx %0d data %h eoh %b err %b, got idx %0d data %h eoh %b err %b",
               what, $realtime, want.word_index, want.header_word, want.end_of_header,
               want.length_error, got.word_index, got.header_word, got.end_of_header,
               got.length_error);
    end
  endtask

  // compare one emitted header word with the oldest prediction
  task automatic check_word(input out_item_t got);
    out_item_t want;
    if (hdr_q.size() == 0) begin
      report("unexpected header word", '0, got);
    end else begin
      want = hdr_q.pop_front();
      n_words++;
      if (got.header_word !== want.header_word || got.word_index !== want.word_index ||
          got.end_of_header !== want.end_of_header ||
          got.length_error !== want.length_error) begin
        report("header word mismatch", want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs = '0;
      pay_sum = '0;
      pay_bytes = '0;
      hdr_q.delete();
      n_err = 0;
      n_items = 0;
      n_words = 0;
    end else begin
      if (out_valid && out_ready) check_word(out_item);
      if (in_valid && in_ready) begin
        absorb_item(in_item);
        n_items++;
      end
      // register writes; indexes past the ident register are ignored
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SRC_ADDR: regs.source_address      = cfg_wdata;
          CFG_DST_ADDR: regs.destination_address = cfg_wdata;
          CFG_SRC_PORT: regs.source_port         = cfg_wdata[15:0];
          CFG_DST_PORT: regs.destination_port    = cfg_wdata[15:0];
          CFG_IP_IDENT: regs.ip_ident            = cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
    mismatches    <= n_err;
    pending       <= hdr_q.size();
    items_taken   <= n_items;
    words_checked <= n_words;
  end

endmodule

// ===== bench/tb.sv =====
// Top of the header builder bench: clock, reset, payload and config stimulus, verdict.
// Depends on tcphb_pkg, tcp_ipv4_header_builder and tcphb_checker.
module tb import tcphb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  int mismatches;
  int pending;
  int items_taken;
  int words_checked;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;
  logic hold_req = 1'b0;

  tcp_ipv4_header_builder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  tcphb_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending), .items_taken(items_taken),
    .words_checked(words_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // header receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    logic hold_done;
    int   held;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        held = 0;
        while (held < 400) begin
          @(posedge clk);
          held++;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t mk(input logic [15:0] w, input logic [1:0] cnt,
                                  input logic last, input logic [31:0] seq,
                                  input logic [31:0] ack, input logic [2:0] flags);
    in_item_t it;
    it.payload_word = w;
    it.byte_count = cnt;
    it.last_item = last;
    it.sequence_number = seq;
    it.ack_number = ack;
    it.tcp_flags = flags;
    return it;
  endfunction

  function automatic cfg_regs_t rand_cfg();
    cfg_regs_t c;
    c.source_address = pick32();
    c.destination_address = pick32();
    c.source_port = 16'(pick32());
    c.destination_port = 16'(pick32());
    c.ip_ident = 16'(pick32());
    return c;
  endfunction

  // offer one item after a random gap and wait until it is taken
  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // wait until every item is taken and every header word has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (items_taken != items_sent || pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // all five registers, then the unused indexes with junk; upper bits of port and ident data are junk
  task automatic load_config(input cfg_regs_t c);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SRC_ADDR;
    cfg_wdata <= c.source_address;
    @(posedge clk);
    cfg_index <= CFG_DST_ADDR;
    cfg_wdata <= c.destination_address;
    @(posedge clk);
    cfg_index <= CFG_SRC_PORT;
    cfg_wdata <= {16'($urandom), c.source_port};
    @(posedge clk);
    cfg_index <= CFG_DST_PORT;
    cfg_wdata <= {16'($urandom), c.destination_port};
    @(posedge clk);
    cfg_index <= CFG_IP_IDENT;
    cfg_wdata <= {16'($urandom), c.ip_ident};
    @(posedge clk);
    for (int i = int'(CFG_IP_IDENT) + 1; i < 8; i++) begin
      cfg_index <= 3'(i);
      cfg_wdata <= $urandom;
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // mostly full words; odd byte counts now and then, anywhere in the packet
  task automatic random_packet(input int max_len);
    int len;
    logic [1:0] cnt;
    len = $urandom_range(max_len, 1);
    for (int k = 0; k < len; k++) begin
      if (k == len - 1 || $urandom_range(7) == 0) cnt = 2'($urandom_range(3));
      else cnt = 2'd2;
      send_item(mk(16'($urandom), cnt, k == len - 1, pick32(), pick32(),
                   3'($urandom_range(7))));
    end
  endtask

  initial begin : stimulus
    int phase_start;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty packet with all registers at reset
    send_item(mk(16'h0000, 2'd0, 1'b1, '0, '0, 3'd0));
    drain();

    // all-ones registers; short words inside and at the end of packets
    load_config('1);
    send_item(mk(16'hffff, 2'd2, 1'b0, '0, '0, 3'd0));
    send_item(mk(16'hffff, 2'd3, 1'b0, '0, '0, 3'd0));
    send_item(mk(16'h1234, 2'd1, 1'b0, '0, '0, 3'd0));
    send_item(mk(16'habcd, 2'd0, 1'b0, '0, '0, 3'd0));
    send_item(mk(16'hffff, 2'd2, 1'b1, '1, '1, 3'd7));
    send_item(mk(16'ha5c3, 2'd1, 1'b1, '0, '1, 3'd1));
    send_item(mk(16'h5a3c, 2'd3, 1'b1, 32'h8000_0001, '0, 3'd2));
    send_item(mk(16'h0001, 2'd2, 1'b0, '0, '0, 3'd0));
    send_item(mk(16'h8000, 2'd2, 1'b1, $urandom, $urandom, 3'd4));
    send_item(mk(16'hff00, 2'd2, 1'b0, '0, '0, 3'd0));
    send_item(mk(16'h00ff, 2'd2, 1'b0, '0, '0, 3'd0));
    send_item(mk(16'hffff, 2'd1, 1'b1, $urandom, $urandom, 3'd0));
    drain();

    // random packets under four handshake mixes
    for (int m = 0; m < 4; m++) begin
      case (m)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      load_config(rand_cfg());
      phase_start = items_sent;
      while (items_sent - phase_start < 58) random_packet(8);
      drain();
    end

    // receiver holds off while short packets keep coming, so the input backs up
    send_idle_pct = 0;
    recv_stall_pct = 0;
    load_config(rand_cfg());
    hold_req = 1'b1;
    repeat (10) random_packet(2);
    drain();

    $display("Covered %0d payload items and %0d header words: empty, short and padded",
             items_sent, words_checked);
    $display("packets, all registers, four handshake mixes and one long output stall.");
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
